// File: sv/cedly_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and the stage gain table of the cascaded echo delay.
// No dependencies; imported by the core.
package cedly_pkg;

   // Defaults for the core parameters.
   localparam int DEFAULT_LINE_DEPTH  = 131072;
   localparam int DEFAULT_MAX_STAGES  = 4;
   localparam int DEFAULT_SAMPLE_BITS = 24;

   // Register file.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int DELAY_BITS    = 17;
   localparam int STAGES_BITS   = 3;

   localparam logic [DELAY_BITS-1:0]  DELAY_RESET  = 17'd24000;
   localparam logic [STAGES_BITS-1:0] STAGES_RESET = 3'd4;

   typedef enum logic [0:0] {
      CSR_DELAY  = 1'b0,
      CSR_STAGES = 1'b1
   } csr_index_type;

   // Q1.15 gains.
   localparam int GAIN_BITS = 16;
   localparam int GAIN_FRAC = 15;

   // Result queue; a power of two so the pointers wrap on their own.
   localparam int OUT_DEPTH = 4;

   // Gain of stage idx (0 = first stage); stages past the fourth use 0.7.
   function automatic logic signed [GAIN_BITS-1:0] stage_gain(input int idx);
      logic signed [GAIN_BITS-1:0] g;
      case (idx)
         0:       g = 16'sd13107;
         1:       g = 16'sd22938;
         2:       g = 16'sd26214;
         3:       g = 16'sd22938;
         default: g = 16'sd22938;
      endcase
      return g;
   endfunction

endpackage

// File: sv/cascaded_echo_delay_core.sv
`timescale 1ns / 1ps
// Cascaded echo delay: chained RAM delay stages, dry sample plus weighted taps, saturation.
// Depends on cedly_pkg and cedly_ram.
//
//   channel  ports                                      direction  carries
//   req      req_valid/req_stall, req_sample_in,         in         dry sample + frame mark
//            req_frame_end
//   rsp      rsp_valid/rsp_stall, rsp_sample_out,        out        echo mix + frame mark
//            rsp_frame_end_out
//   csr      psel/penable/pwrite/paddr/pwdata/prdata/    in/out     delay_samples @0x0,
//            pready                                                 stage_count @0x4
//
// Throughput is one request per clock while req_stall is low. The delay line read is
// launched on the accepting edge; the next cycle takes the registered RAM word, resolves
// the chain and forms the gain products, the cycle after sums, rounds and saturates, and
// the result is written into a four-entry result queue and shown from there.
// After reset the core sweeps every delay line to zero, one address per clock, over all
// LINE_DEPTH addresses (131072 at the default depth); req_stall stays high during the sweep,
// while register writes are taken as usual.
// req_stall rises when four requests are in flight, so a stalled rsp side never drops work.
module cascaded_echo_delay_core
   import cedly_pkg::*;
#(
   parameter int LINE_DEPTH  = DEFAULT_LINE_DEPTH,
   parameter int MAX_STAGES  = DEFAULT_MAX_STAGES,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_frame_end,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_frame_end_out,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   localparam int AW     = $clog2(LINE_DEPTH);
   localparam int AW1    = AW + 1;
   localparam int CW     = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
   localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;
   localparam int ACC_W  = PROD_W + $clog2(MAX_STAGES + 1);
   localparam int PTR_W  = $clog2(OUT_DEPTH);
   localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (GAIN_FRAC - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   frame_end;
   } rsp_entry_type;

   // ------------------------------------------------------------------ registers
   logic [DELAY_BITS-1:0]  delay_ff;
   logic [STAGES_BITS-1:0] stages_ff;

   // Post-reset sweep of the delay lines.
   logic          clear_ff;
   logic [AW-1:0] clear_addr_ff;

   logic [AW-1:0] wp_ff, wp_in;

   // Stage 1: RAM data arrives, chain resolves, lines are written, products formed.
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_dry_ff;
   logic                          s1_frame_ff;
   logic [AW-1:0]                 s1_wp_ff;
   logic                          s1_fwd_ff;
   logic signed [SAMPLE_BITS-1:0] s1_fwd_data_ff [MAX_STAGES];

   // Stage 2: products registered, summed and saturated into the queue.
   logic                          s2_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s2_dry_ff;
   logic                          s2_frame_ff;
   logic signed [PROD_W-1:0]      s2_prod_ff [MAX_STAGES];

   rsp_entry_type    fifo_mem_ff [OUT_DEPTH];
   logic [PTR_W-1:0] fifo_wr_ff, fifo_rd_ff;
   logic [CNT_W-1:0] fifo_count_ff, fifo_count_in;
   logic [CNT_W-1:0] inflight_ff, inflight_in;

   // ------------------------------------------------------------------ combinational
   logic                          req_accept;
   logic                          rsp_accept;
   logic [CW-1:0]                 delay_wide;
   logic [AW-1:0]                 delay_eff;
   logic                          zero_delay;
   logic [AW-1:0]                 rp;
   logic                          fwd_hit;
   logic [MAX_STAGES-1:0]         stage_on;
   logic signed [SAMPLE_BITS-1:0] ram_rd   [MAX_STAGES];
   logic signed [SAMPLE_BITS-1:0] tap_rd   [MAX_STAGES];
   logic signed [SAMPLE_BITS-1:0] tap_out  [MAX_STAGES];
   logic signed [SAMPLE_BITS-1:0] tap_in   [MAX_STAGES];
   logic signed [PROD_W-1:0]      tap_prod [MAX_STAGES];
   logic signed [ACC_W-1:0]       acc;
   logic signed [ACC_W-1:0]       rnd;
   logic signed [ACC_W-1:0]       sat;

   // ------------------------------------------------------------------ register port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         stages_ff <= STAGES_RESET;
      end else if (psel && penable && pwrite) begin
         // Byte lane bits of paddr are ignored; bit 2 picks the register.
         unique case (csr_index_type'(paddr[2]))
            CSR_DELAY:  delay_ff  <= pwdata[DELAY_BITS-1:0];
            CSR_STAGES: stages_ff <= pwdata[STAGES_BITS-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(paddr[2]))
         CSR_DELAY:  prdata = CSR_DATA_BITS'(delay_ff);
         CSR_STAGES: prdata = CSR_DATA_BITS'(stages_ff);
         default:    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------ handshakes
   assign req_stall  = clear_ff || (inflight_ff == CNT_W'(OUT_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (fifo_count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   // ------------------------------------------------------------------ addressing
   always_comb begin
      // Clamp the delay to the line length.
      delay_wide = CW'(delay_ff);
      if (delay_wide > CW'(LINE_DEPTH - 1)) begin
         delay_eff = AW'(LINE_DEPTH - 1);
      end else begin
         delay_eff = delay_wide[AW-1:0];
      end
      zero_delay = (delay_eff == '0);

      // Read position trails the write position, wrapping at the line length.
      if (wp_ff >= delay_eff) begin
         rp = wp_ff - delay_eff;
      end else begin
         rp = AW'(AW1'(wp_ff) + AW1'(LINE_DEPTH) - AW1'(delay_eff));
      end

      if (wp_ff == AW'(LINE_DEPTH - 1)) begin
         wp_in = '0;
      end else begin
         wp_in = wp_ff + AW'(1);
      end

      // The request in stage 1 writes this very address in the cycle of our read;
      // the RAM returns the old word, so take the written word instead.
      fwd_hit = s1_valid_ff && (rp == s1_wp_ff);
   end

   // ------------------------------------------------------------------ delay lines
   for (genvar j = 0; j < MAX_STAGES; j++) begin : g_line
      logic                   line_we;
      logic [AW-1:0]          line_waddr;
      logic [SAMPLE_BITS-1:0] line_wdata;
      logic [SAMPLE_BITS-1:0] line_rdata;

      // Requests do not write stages at or past the stage count; the sweep still clears them.
      assign stage_on[j] = (int'(stages_ff) > j);

      assign line_we    = clear_ff || (s1_valid_ff && stage_on[j]);
      assign line_waddr = clear_ff ? clear_addr_ff : s1_wp_ff;
      assign line_wdata = clear_ff ? '0 : tap_in[j];
      assign ram_rd[j]  = line_rdata;

      cedly_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (LINE_DEPTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (line_we),
         .wr_addr (line_waddr),
         .wr_data (line_wdata),
         .rd_addr (rp),
         .rd_data (line_rdata)
      );
   end

   // Chain: each stage passes on its delayed word; with zero delay every stage passes
   // the dry sample straight through.
   always_comb begin
      for (int j = 0; j < MAX_STAGES; j++) begin
         tap_rd[j]  = s1_fwd_ff ? s1_fwd_data_ff[j] : ram_rd[j];
         tap_out[j] = zero_delay ? s1_dry_ff : tap_rd[j];
      end
      tap_in[0] = s1_dry_ff;
      for (int j = 1; j < MAX_STAGES; j++) begin
         tap_in[j] = tap_out[j-1];
      end
      for (int j = 0; j < MAX_STAGES; j++) begin
         if (stage_on[j]) begin
            tap_prod[j] = PROD_W'(stage_gain(j)) * PROD_W'(tap_out[j]);
         end else begin
            tap_prod[j] = '0;
         end
      end
   end

   // ------------------------------------------------------------------ mix and saturate
   always_comb begin
      acc = ACC_W'(s2_dry_ff) <<< GAIN_FRAC;
      for (int j = 0; j < MAX_STAGES; j++) begin
         acc = acc + ACC_W'(s2_prod_ff[j]);
      end
      // Round half up, then clip to the sample range.
      rnd = (acc + ROUND_HALF) >>> GAIN_FRAC;
      if (rnd > SAT_HI) begin
         sat = SAT_HI;
      end else if (rnd < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = rnd;
      end
   end

   // ------------------------------------------------------------------ control state
   always_comb begin
      fifo_count_in = fifo_count_ff;
      if (s2_valid_ff && !rsp_accept) begin
         fifo_count_in = fifo_count_ff + CNT_W'(1);
      end else if (!s2_valid_ff && rsp_accept) begin
         fifo_count_in = fifo_count_ff - CNT_W'(1);
      end

      inflight_in = inflight_ff;
      if (req_accept && !rsp_accept) begin
         inflight_in = inflight_ff + CNT_W'(1);
      end else if (!req_accept && rsp_accept) begin
         inflight_in = inflight_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         wp_ff         <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         fifo_wr_ff    <= '0;
         fifo_rd_ff    <= '0;
         fifo_count_ff <= '0;
         inflight_ff   <= '0;
      end else begin
         // Sweep the lines once, then open the request side.
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(LINE_DEPTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (req_accept) begin
            wp_ff <= wp_in;
         end
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            fifo_wr_ff <= fifo_wr_ff + PTR_W'(1);
         end
         if (rsp_accept) begin
            fifo_rd_ff <= fifo_rd_ff + PTR_W'(1);
         end
         fifo_count_ff <= fifo_count_in;
         inflight_ff   <= inflight_in;
      end
   end

   // ------------------------------------------------------------------ datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_dry_ff   <= req_sample_in;
         s1_frame_ff <= req_frame_end;
         s1_wp_ff    <= wp_ff;
         s1_fwd_ff   <= fwd_hit;
         for (int j = 0; j < MAX_STAGES; j++) begin
            s1_fwd_data_ff[j] <= tap_in[j];
         end
      end
      if (s1_valid_ff) begin
         s2_dry_ff   <= s1_dry_ff;
         s2_frame_ff <= s1_frame_ff;
         for (int j = 0; j < MAX_STAGES; j++) begin
            s2_prod_ff[j] <= tap_prod[j];
         end
      end
      if (s2_valid_ff) begin
         fifo_mem_ff[fifo_wr_ff] <= '{sample: sat[SAMPLE_BITS-1:0], frame_end: s2_frame_ff};
      end
   end

   assign rsp_sample_out    = fifo_mem_ff[fifo_rd_ff].sample;
   assign rsp_frame_end_out = fifo_mem_ff[fifo_rd_ff].frame_end;

   // ------------------------------------------------------------------ assertions
   // Credit count stays within the queue.
   assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(OUT_DEPTH))
      else $error("in-flight count exceeds result queue depth");

   // Every request in flight sits in exactly one place: stage 1, stage 2 or the queue.
   assert property (@(posedge clock) disable iff (reset)
      inflight_ff == fifo_count_ff + CNT_W'(s1_valid_ff) + CNT_W'(s2_valid_ff))
      else $error("in-flight count disagrees with pipeline occupancy");

   // No request enters while the lines are being swept.
   assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (inflight_ff == '0) && !s1_valid_ff)
      else $error("request in flight during line sweep");

   // The queue never takes a result while full.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (fifo_count_ff != CNT_W'(OUT_DEPTH)) || rsp_accept)
      else $error("result queue overflow");

endmodule

// File: sv/cedly_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read (read-first).
// No dependencies.
module cedly_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
